@@ rtl/abm4_pkg.sv @@
// ----------------------------------------------------------------------------
// abm4_pkg
// Shared types, constants and fixed-point helpers of the ABM4 ODE stepper.
// ----------------------------------------------------------------------------
package abm4_pkg;

    localparam int MAX_STEPS  = 1024;
    localparam int FRAC_BITS  = 16;

    localparam int DATA_W     = 32;
    localparam int DT_W       = 17;
    localparam int CNT_W      = 11;
    localparam int TOL_W      = 32;
    localparam int LIM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SUM_W      = 42;
    localparam int HALF_W     = SUM_W / 2;
    localparam int PP_W       = DT_W + HALF_W;
    localparam int PROD_W     = DT_W + SUM_W;
    localparam int QUO_W      = PROD_W - FRAC_BITS + 1;
    localparam int DIV_DIGITS = 4;
    localparam int DIV_STEPS  = (QUO_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int QPAD_W     = DIV_STEPS * DIV_DIGITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int Y_W        = QUO_W + 1;
    localparam int SAT_W      = Y_W + 3;

    typedef logic signed [DATA_W-1:0] t_fx;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_S = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_T = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd5;

    localparam logic [DATA_W-1:0] RST_INIT_S = 32'd65536;
    localparam logic [DATA_W-1:0] RST_INIT_T = 32'd0;
    localparam logic [DT_W-1:0]   RST_DT     = 17'd6554;
    localparam logic [CNT_W-1:0]  RST_COUNT  = 11'd20;
    localparam logic [TOL_W-1:0]  RST_TOL    = 32'd1;
    localparam logic [LIM_W-1:0]  RST_LIMIT  = 8'd50;

    localparam logic [CNT_W-1:0] STARTUP_STEPS = 11'd3;

    typedef enum logic [1:0] {
        DIV_1,
        DIV_2,
        DIV_6,
        DIV_24
    } t_div;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_RESTART,
        CMD_F1,
        CMD_F2,
        CMD_F3,
        CMD_F4,
        CMD_RKEND,
        CMD_AB,
        CMD_CORR,
        CMD_TMUL,
        CMD_TCMP,
        CMD_FIN,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic scale_done;
        logic conv_now;
        logic limit_hit;
        logic running;
        logic at_final;
        logic early;
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0] step_index;
        t_fx              time_value;
        t_fx              solution_value;
        logic             from_startup;
        logic [LIM_W-1:0] iterations_used;
        logic             converged;
        logic             done_res;
    } t_rsp;

    function automatic t_fx sat_fx(input logic signed [SAT_W-1:0] x);
        t_fx r;
        if (&x[SAT_W-1:DATA_W-1] || ~|x[SAT_W-1:DATA_W-1]) begin
            r = x[DATA_W-1:0];
        end else if (x[SAT_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // F(s,t) = -s + t + 1
    function automatic t_fx deriv_fx(input t_fx s, input t_fx t);
        logic signed [SAT_W-1:0] w;
        w = SAT_W'(t) - SAT_W'(s) + (SAT_W'(1) <<< FRAC_BITS);
        return sat_fx(w);
    endfunction

endpackage

@@ rtl/abm4_if.sv @@
// ----------------------------------------------------------------------------
// abm4 channel interfaces
// Request channel (restart flag) and response channel (one step result).
// ----------------------------------------------------------------------------
interface abm4_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface abm4_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [abm4_pkg::CNT_W-1:0]     step_index;
    logic signed [abm4_pkg::DATA_W-1:0] time_value;
    logic signed [abm4_pkg::DATA_W-1:0] solution_value;
    logic                           from_startup;
    logic [abm4_pkg::LIM_W-1:0]     iterations_used;
    logic                           converged;
    logic                           done_res;

    modport source (output valid, output step_index, output time_value,
                    output solution_value, output from_startup,
                    output iterations_used, output converged, output done_res,
                    input ready);
    modport sink   (input valid, input step_index, input time_value,
                    input solution_value, input from_startup,
                    input iterations_used, input converged, input done_res,
                    output ready);
endinterface

@@ rtl/abm4_ode_stepper_top.sv @@
// ----------------------------------------------------------------------------
// abm4_ode_stepper_top
// Fourth-order Adams-Bashforth-Moulton stepper for dS/dt = -S + t + 1, Q16.16.
//
//   channel  direction  payload
//   i_req    in         restart
//   o_rsp    out        step_index, time_value, solution_value, from_startup,
//                       iterations_used, converged, done_res
//   i_cfg_*  in         register index and write data, no read-back
//
// one step at a time; a scaling pass uses the shared 17x21 multiplier and
// the radix-16 divide-by-three unit
// restart and re-emit go straight to EMIT; an RK4 step runs the F1 to F4 passes,
// RKEND and FIN; a corrector step runs AB, then CORR, TMUL, TCMP per pass, then FIN
// reset: synchronous, loads the register defaults, no step is running
// the next request is taken while a result waits in the output register
// ----------------------------------------------------------------------------
module abm4_ode_stepper_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    abm4_req_if.sink                        i_req,
    abm4_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [abm4_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abm4_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    abm4_pkg::t_cmd    cmd;
    abm4_pkg::t_status status;
    abm4_pkg::t_rsp    rsp;
    logic              req_ready, rsp_valid;

    abm4_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_restart (i_req.restart),
        .o_req_ready   (req_ready),
        .o_rsp_valid   (rsp_valid),
        .i_rsp_ready   (o_rsp.ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    abm4_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_rsp      (rsp)
    );

    assign i_req.ready           = req_ready;
    assign o_rsp.valid           = rsp_valid;
    assign o_rsp.step_index      = rsp.step_index;
    assign o_rsp.time_value      = rsp.time_value;
    assign o_rsp.solution_value  = rsp.solution_value;
    assign o_rsp.from_startup    = rsp.from_startup;
    assign o_rsp.iterations_used = rsp.iterations_used;
    assign o_rsp.converged       = rsp.converged;
    assign o_rsp.done_res        = rsp.done_res;

endmodule

@@ rtl/abm4_scale.sv @@
// ----------------------------------------------------------------------------
// abm4_scale
// Multicycle dt*sum/(k*2^FRAC_BITS), round half away from zero, k in 1,2,6,24.
// ----------------------------------------------------------------------------
module abm4_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [abm4_pkg::SUM_W-1:0]  i_sum,
    input  abm4_pkg::t_div                     i_div,
    input  logic [abm4_pkg::DT_W-1:0]          i_dt,
    output logic                               o_done,
    output logic signed [abm4_pkg::Y_W-1:0]    o_y
);

    typedef enum logic [6:0] {
        SC_IDLE  = 7'b0000001,
        SC_LOAD  = 7'b0000010,
        SC_MLO   = 7'b0000100,
        SC_MHI   = 7'b0001000,
        SC_SHIFT = 7'b0010000,
        SC_DIV   = 7'b0100000,
        SC_DONE  = 7'b1000000
    } t_sc_state;

    t_sc_state                           r_state, n_state;
    logic                                r_neg;
    logic [abm4_pkg::SUM_W-1:0]          r_mag;
    logic [abm4_pkg::PROD_W-1:0]         r_prod;
    logic [abm4_pkg::QPAD_W-1:0]         r_quo;
    logic [abm4_pkg::DIV_CNT_W-1:0]      r_dcnt;

    logic [abm4_pkg::HALF_W-1:0]         half_op;
    logic [abm4_pkg::PP_W-1:0]           pp;
    logic [abm4_pkg::PROD_W:0]           rounded;
    logic [abm4_pkg::PROD_W:0]           round_c;
    int                                  sh;
    logic                                div3;
    logic signed [abm4_pkg::Y_W-1:0]     mag_s;

    assign half_op = (r_state == SC_MLO) ? r_mag[abm4_pkg::HALF_W-1:0]
                                         : r_mag[abm4_pkg::SUM_W-1:abm4_pkg::HALF_W];
    assign pp = i_dt * half_op;

    always_comb begin
        case (i_div)
            abm4_pkg::DIV_1: begin
                sh = abm4_pkg::FRAC_BITS;     round_c = (abm4_pkg::PROD_W+1)'(1);
                div3 = 1'b0;
            end
            abm4_pkg::DIV_2: begin
                sh = abm4_pkg::FRAC_BITS + 1; round_c = (abm4_pkg::PROD_W+1)'(2);
                div3 = 1'b0;
            end
            abm4_pkg::DIV_6: begin
                sh = abm4_pkg::FRAC_BITS + 1; round_c = (abm4_pkg::PROD_W+1)'(6);
                div3 = 1'b1;
            end
            default: begin
                sh = abm4_pkg::FRAC_BITS + 3; round_c = (abm4_pkg::PROD_W+1)'(24);
                div3 = 1'b1;
            end
        endcase
        rounded = (abm4_pkg::PROD_W+1)'(r_prod)
                + (round_c << (abm4_pkg::FRAC_BITS - 1));
    end

    // remainder bits of the digit loop carry between cycles
    logic [1:0] r_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE:  if (i_start) n_state = SC_LOAD;
            SC_LOAD:  n_state = SC_MLO;
            SC_MLO:   n_state = SC_MHI;
            SC_MHI:   n_state = SC_SHIFT;
            SC_SHIFT: n_state = div3 ? SC_DIV : SC_DONE;
            SC_DIV:   if (r_dcnt == '0) n_state = SC_DONE;
            SC_DONE:  n_state = SC_IDLE;
            default:  n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic [abm4_pkg::QPAD_W-1:0] quo_step;
    logic [1:0]                  rem_out;

    // divide by three, four quotient bits per cycle
    always_comb begin
        logic [1:0] rr;
        logic [2:0] tt;
        rr       = r_rem;
        quo_step = '0;
        for (int i = 0; i < abm4_pkg::DIV_DIGITS; i++) begin
            tt = {rr, r_quo[abm4_pkg::QPAD_W-1-i]};
            if (tt >= 3'd3) begin
                quo_step[abm4_pkg::DIV_DIGITS-1-i] = 1'b1;
                tt = tt - 3'd3;
            end
            rr = tt[1:0];
        end
        quo_step[abm4_pkg::QPAD_W-1:abm4_pkg::DIV_DIGITS] =
            r_quo[abm4_pkg::QPAD_W-abm4_pkg::DIV_DIGITS-1:0];
        rem_out = rr;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SC_LOAD: begin
                r_neg <= i_sum[abm4_pkg::SUM_W-1];
                r_mag <= i_sum[abm4_pkg::SUM_W-1] ? abm4_pkg::SUM_W'(-i_sum)
                                                  : abm4_pkg::SUM_W'(i_sum);
            end
            SC_MLO:  r_prod <= abm4_pkg::PROD_W'(pp);
            SC_MHI:  r_prod <= r_prod + (abm4_pkg::PROD_W'(pp) << abm4_pkg::HALF_W);
            SC_SHIFT: begin
                r_quo  <= abm4_pkg::QPAD_W'(rounded >> sh);
                r_rem  <= 2'd0;
                r_dcnt <= abm4_pkg::DIV_CNT_W'(abm4_pkg::DIV_STEPS - 1);
            end
            SC_DIV: begin
                r_quo  <= quo_step;
                r_rem  <= rem_out;
                r_dcnt <= r_dcnt - 1'b1;
            end
            default: ;
        endcase
    end

    assign mag_s  = $signed({1'b0, r_quo[abm4_pkg::QUO_W-1:0]});
    assign o_y    = r_neg ? -mag_s : mag_s;
    assign o_done = (r_state == SC_DONE);

endmodule

@@ rtl/abm4_dp.sv @@
// ----------------------------------------------------------------------------
// abm4_dp
// Datapath: configuration, solution state, derivative history, corrector test.
// ----------------------------------------------------------------------------
module abm4_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [abm4_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [abm4_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  abm4_pkg::t_cmd                    i_cmd,
    output abm4_pkg::t_status                 o_status,
    output abm4_pkg::t_rsp                    o_rsp
);

    abm4_pkg::t_fx                  r_init_s, r_init_t;
    logic [abm4_pkg::DT_W-1:0]      r_dt;
    logic [abm4_pkg::CNT_W-1:0]     r_count;
    logic [abm4_pkg::TOL_W-1:0]     r_tol;
    logic [abm4_pkg::LIM_W-1:0]     r_limit;

    abm4_pkg::t_fx                  r_s, r_t;
    abm4_pkg::t_fx                  r_h [4];
    logic [abm4_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_run;
    logic [abm4_pkg::LIM_W-1:0]     r_iters;
    logic                           r_conv;
    abm4_pkg::t_fx                  r_f1, r_f2, r_f3;
    logic signed [abm4_pkg::SUM_W-1:0] r_sum;
    abm4_pkg::t_div                 r_div;
    abm4_pkg::t_fx                  r_sold, r_snew;
    logic [abm4_pkg::DATA_W-1:0]    r_diff;
    logic [2*abm4_pkg::DATA_W-1:0]  r_prod;
    abm4_pkg::t_rsp                 r_rsp;

    logic                           scale_start, scale_done;
    logic signed [abm4_pkg::Y_W-1:0] y;
    abm4_pkg::t_fx                  v, th, tn, f_th, f_tn, f_st, f_init;
    logic [abm4_pkg::DT_W-1:0]      dt_half;
    logic [abm4_pkg::CNT_W-1:0]     final_step;
    logic [abm4_pkg::LIM_W-1:0]     lim_eff;
    logic signed [abm4_pkg::SAT_W-1:0] diff_w, diff_abs;
    logic signed [abm4_pkg::DATA_W:0]  v_w, v_abs;

    assign scale_start = (i_cmd == abm4_pkg::CMD_F1) || (i_cmd == abm4_pkg::CMD_F2)
                      || (i_cmd == abm4_pkg::CMD_F3) || (i_cmd == abm4_pkg::CMD_F4)
                      || (i_cmd == abm4_pkg::CMD_AB) || (i_cmd == abm4_pkg::CMD_CORR);

    abm4_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scale_start),
        .i_sum   (r_sum),
        .i_div   (r_div),
        .i_dt    (r_dt),
        .o_done  (scale_done),
        .o_y     (y)
    );

    assign dt_half = abm4_pkg::DT_W'(((abm4_pkg::DT_W+1)'(r_dt) + 1'b1) >> 1);
    assign v   = abm4_pkg::sat_fx(abm4_pkg::SAT_W'(r_s) + abm4_pkg::SAT_W'(y));
    assign th  = abm4_pkg::sat_fx(abm4_pkg::SAT_W'(r_t)
                 + $signed(abm4_pkg::SAT_W'(dt_half)));
    assign tn  = abm4_pkg::sat_fx(abm4_pkg::SAT_W'(r_t)
                 + $signed(abm4_pkg::SAT_W'(r_dt)));
    assign f_th   = abm4_pkg::deriv_fx(v, th);
    assign f_tn   = abm4_pkg::deriv_fx(v, tn);
    assign f_st   = abm4_pkg::deriv_fx(r_s, r_t);
    assign f_init = abm4_pkg::deriv_fx(r_init_s, r_init_t);

    assign final_step = (r_count > abm4_pkg::CNT_W'(abm4_pkg::MAX_STEPS))
                      ? abm4_pkg::CNT_W'(abm4_pkg::MAX_STEPS) : r_count;
    assign lim_eff    = (r_limit == '0) ? abm4_pkg::LIM_W'(1) : r_limit;

    assign diff_w   = abm4_pkg::SAT_W'(v) - abm4_pkg::SAT_W'(r_sold);
    assign diff_abs = diff_w[abm4_pkg::SAT_W-1] ? -diff_w : diff_w;
    assign v_w      = (abm4_pkg::DATA_W+1)'(v);
    assign v_abs    = v_w[abm4_pkg::DATA_W] ? -v_w : v_w;

    assign o_status.scale_done = scale_done;
    assign o_status.conv_now   = {r_diff, {abm4_pkg::DATA_W{1'b0}}} < r_prod;
    assign o_status.limit_hit  = r_iters >= lim_eff;
    assign o_status.running    = r_run;
    assign o_status.at_final   = r_cnt >= final_step;
    assign o_status.early      = r_cnt < abm4_pkg::STARTUP_STEPS;
    assign o_rsp               = r_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_s <= abm4_pkg::RST_INIT_S;
            r_init_t <= abm4_pkg::RST_INIT_T;
            r_dt     <= abm4_pkg::RST_DT;
            r_count  <= abm4_pkg::RST_COUNT;
            r_tol    <= abm4_pkg::RST_TOL;
            r_limit  <= abm4_pkg::RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                abm4_pkg::CFG_INIT_S: r_init_s <= i_cfg_data;
                abm4_pkg::CFG_INIT_T: r_init_t <= i_cfg_data;
                abm4_pkg::CFG_DT:     r_dt     <= i_cfg_data[abm4_pkg::DT_W-1:0];
                abm4_pkg::CFG_COUNT:  r_count  <= i_cfg_data[abm4_pkg::CNT_W-1:0];
                abm4_pkg::CFG_TOL:    r_tol    <= i_cfg_data;
                abm4_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[abm4_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_cnt   <= '0;
            r_iters <= '0;
            r_conv  <= 1'b0;
            r_s     <= '0;
            r_t     <= '0;
            for (int i = 0; i < 4; i++) r_h[i] <= '0;
        end else begin
            unique case (i_cmd) inside
                abm4_pkg::CMD_RESTART: begin
                    r_s     <= r_init_s;
                    r_t     <= r_init_t;
                    r_h[0]  <= '0;
                    r_h[1]  <= '0;
                    r_h[2]  <= '0;
                    r_h[3]  <= f_init;
                    r_cnt   <= '0;
                    r_run   <= 1'b1;
                    r_iters <= '0;
                    r_conv  <= 1'b0;
                end
                abm4_pkg::CMD_F1, abm4_pkg::CMD_AB: begin
                    r_iters <= '0;
                    r_conv  <= 1'b0;
                end
                abm4_pkg::CMD_TMUL: r_iters <= r_iters + 1'b1;
                abm4_pkg::CMD_TCMP: r_conv  <= o_status.conv_now;
                abm4_pkg::CMD_FIN: begin
                    r_s    <= r_snew;
                    r_t    <= tn;
                    r_h[0] <= r_h[1];
                    r_h[1] <= r_h[2];
                    r_h[2] <= r_h[3];
                    r_h[3] <= abm4_pkg::deriv_fx(r_snew, tn);
                    r_cnt  <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // operands and scratch registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            abm4_pkg::CMD_F1: begin
                r_f1  <= f_st;
                r_sum <= abm4_pkg::SUM_W'(f_st);
                r_div <= abm4_pkg::DIV_2;
            end
            abm4_pkg::CMD_F2: begin
                r_f2  <= f_th;
                r_sum <= abm4_pkg::SUM_W'(f_th);
                r_div <= abm4_pkg::DIV_2;
            end
            abm4_pkg::CMD_F3: begin
                r_f3  <= f_th;
                r_sum <= abm4_pkg::SUM_W'(f_th);
                r_div <= abm4_pkg::DIV_1;
            end
            abm4_pkg::CMD_F4: begin
                r_sum <= abm4_pkg::SUM_W'(r_f1) + (abm4_pkg::SUM_W'(r_f2) <<< 1)
                       + (abm4_pkg::SUM_W'(r_f3) <<< 1) + abm4_pkg::SUM_W'(f_tn);
                r_div <= abm4_pkg::DIV_6;
            end
            abm4_pkg::CMD_RKEND: r_snew <= v;
            abm4_pkg::CMD_AB: begin
                r_sum <= 55 * abm4_pkg::SUM_W'(r_h[3]) - 59 * abm4_pkg::SUM_W'(r_h[2])
                       + 37 * abm4_pkg::SUM_W'(r_h[1]) - 9 * abm4_pkg::SUM_W'(r_h[0]);
                r_div <= abm4_pkg::DIV_24;
            end
            abm4_pkg::CMD_CORR: begin
                r_sold <= v;
                r_sum  <= abm4_pkg::SUM_W'(r_h[1]) - 5 * abm4_pkg::SUM_W'(r_h[2])
                        + 19 * abm4_pkg::SUM_W'(r_h[3]) + 9 * abm4_pkg::SUM_W'(f_tn);
                r_div  <= abm4_pkg::DIV_24;
            end
            abm4_pkg::CMD_TMUL: begin
                r_snew <= v;
                r_diff <= abm4_pkg::DATA_W'(diff_abs);
                r_prod <= r_tol * v_abs[abm4_pkg::DATA_W-1:0];
            end
            abm4_pkg::CMD_EMIT: begin
                if (!r_run) begin
                    r_rsp <= '0;
                end else begin
                    r_rsp.step_index      <= r_cnt;
                    r_rsp.time_value      <= r_t;
                    r_rsp.solution_value  <= r_s;
                    r_rsp.from_startup    <= r_cnt <= abm4_pkg::STARTUP_STEPS;
                    r_rsp.iterations_used <= r_iters;
                    r_rsp.converged       <= r_conv;
                    r_rsp.done_res        <= o_status.at_final;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/abm4_ctrl.sv @@
// ----------------------------------------------------------------------------
// abm4_ctrl
// Step sequencer: restart, RK4 startup, predictor and corrector loop, output.
// ----------------------------------------------------------------------------
module abm4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_restart,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  abm4_pkg::t_status i_status,
    output abm4_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_F1    = 13'b0000000000010,
        ST_F2    = 13'b0000000000100,
        ST_F3    = 13'b0000000001000,
        ST_F4    = 13'b0000000010000,
        ST_RKEND = 13'b0000000100000,
        ST_AB    = 13'b0000001000000,
        ST_CORR  = 13'b0000010000000,
        ST_TMUL  = 13'b0000100000000,
        ST_TCMP  = 13'b0001000000000,
        ST_FIN   = 13'b0010000000000,
        ST_EMIT  = 13'b0100000000000,
        ST_WAIT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_state r_after, n_after;
    logic   r_ovalid, n_ovalid;
    logic   accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_ovalid = r_ovalid && !i_rsp_ready;
        o_cmd    = abm4_pkg::CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_restart) begin
                        o_cmd   = abm4_pkg::CMD_RESTART;
                        n_state = ST_EMIT;
                    end else if (!i_status.running || i_status.at_final) begin
                        n_state = ST_EMIT;
                    end else if (i_status.early) begin
                        n_state = ST_F1;
                    end else begin
                        n_state = ST_AB;
                    end
                end
            end
            ST_F1: begin
                o_cmd = abm4_pkg::CMD_F1; n_state = ST_WAIT; n_after = ST_F2;
            end
            ST_F2: begin
                o_cmd = abm4_pkg::CMD_F2; n_state = ST_WAIT; n_after = ST_F3;
            end
            ST_F3: begin
                o_cmd = abm4_pkg::CMD_F3; n_state = ST_WAIT; n_after = ST_F4;
            end
            ST_F4: begin
                o_cmd = abm4_pkg::CMD_F4; n_state = ST_WAIT; n_after = ST_RKEND;
            end
            ST_RKEND: begin
                o_cmd = abm4_pkg::CMD_RKEND; n_state = ST_FIN;
            end
            ST_AB: begin
                o_cmd = abm4_pkg::CMD_AB; n_state = ST_WAIT; n_after = ST_CORR;
            end
            ST_CORR: begin
                o_cmd = abm4_pkg::CMD_CORR; n_state = ST_WAIT; n_after = ST_TMUL;
            end
            ST_TMUL: begin
                o_cmd = abm4_pkg::CMD_TMUL; n_state = ST_TCMP;
            end
            ST_TCMP: begin
                o_cmd   = abm4_pkg::CMD_TCMP;
                n_state = (i_status.conv_now || i_status.limit_hit) ? ST_FIN : ST_CORR;
            end
            ST_FIN: begin
                o_cmd = abm4_pkg::CMD_FIN; n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ovalid || i_rsp_ready) begin
                    o_cmd    = abm4_pkg::CMD_EMIT;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (i_status.scale_done) n_state = r_after;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_after  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ rtl/abm4_chk.sv @@
// ----------------------------------------------------------------------------
// abm4_chk
// Port-level checks of the ABM4 stepper, bound to the top level.
// ----------------------------------------------------------------------------
module abm4_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [abm4_pkg::CNT_W-1:0]    i_step_index,
    input logic                          i_from_startup,
    input logic [abm4_pkg::LIM_W-1:0]    i_iterations_used,
    input logic                          i_converged
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_step_index <= abm4_pkg::CNT_W'(abm4_pkg::MAX_STEPS))
        else $error("step index beyond maximum");

    a_iters_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_iterations_used != '0 |-> !i_from_startup)
        else $error("startup step with corrector passes");

    a_conv_iters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_converged |-> i_iterations_used != '0)
        else $error("converged without a corrector pass");

    a_rk_startup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_step_index != '0 && i_step_index <= abm4_pkg::STARTUP_STEPS
        |-> i_from_startup)
        else $error("early step not flagged as startup");

endmodule

bind abm4_ode_stepper_top abm4_chk u_abm4_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_step_index      (o_rsp.step_index),
    .i_from_startup    (o_rsp.from_startup),
    .i_iterations_used (o_rsp.iterations_used),
    .i_converged       (o_rsp.converged)
);
